### rtl/gql_pkg.sv
// ----------------------------------------------------------------------------
// gql_pkg
// Shared constants and types of the glyph quad layout block: atlas geometry,
// configuration register indexes and reset values, and the records that
// travel between the cursor, the atlas lookup and the top level.
// ----------------------------------------------------------------------------
package gql_pkg;

    // Font atlas geometry, Q16.16 cell size
    localparam int ATLAS_COLUMNS = 16;
    localparam int CELL_U        = 4096;
    localparam int CELL_V        = 4096;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_LEFT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_U_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_BASE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_CHARS    = 3'd6;

    // Register reset values
    localparam logic [31:0] RST_TEX_LEFT      = 32'd0;
    localparam logic [31:0] RST_GLYPH_U_WIDTH = 32'd4096;
    localparam logic [31:0] RST_V_BASE        = 32'd65536;
    localparam logic [31:0] RST_QUAD_WIDTH    = 32'd65536;
    localparam logic [31:0] RST_QUAD_HEIGHT   = 32'd65536;
    localparam logic [31:0] RST_ADVANCE       = 32'd65536;
    localparam logic [7:0]  RST_WRAP_CHARS    = 8'd0;

    localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] tex_left;
        logic [31:0] glyph_u_width;
        logic [31:0] v_base;
        logic [31:0] quad_width;
        logic [31:0] quad_height;
        logic [31:0] advance;
        logic [7:0]  wrap_chars;
    } t_cfg;

    // Cursor position seen by the current character and the line count after it
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] line_count;
    } t_cursor;

    // Texture corners of one glyph
    typedef struct packed {
        logic [31:0] u0;
        logic [31:0] u1;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_tex;

    // One finished glyph quad
    typedef struct packed {
        logic [31:0] pos_x0;
        logic [31:0] pos_x1;
        logic [31:0] pos_y0;
        logic [31:0] pos_y1;
        logic [31:0] tex_u0;
        logic [31:0] tex_u1;
        logic [31:0] tex_v0;
        logic [31:0] tex_v1;
        logic [15:0] line_count;
    } t_quad;

endpackage

### rtl/gql_ifs.sv
// ----------------------------------------------------------------------------
// gql channel interfaces
// Valid/ready channels for character requests in and glyph quads out.
// ----------------------------------------------------------------------------
interface gql_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_text;

    modport source (output valid, output char_code, output start_text, input ready);
    modport sink   (input valid, input char_code, input start_text, output ready);
endinterface

interface gql_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x0;
    logic signed [31:0] pos_x1;
    logic signed [31:0] pos_y0;
    logic signed [31:0] pos_y1;
    logic signed [31:0] tex_u0;
    logic signed [31:0] tex_u1;
    logic signed [31:0] tex_v0;
    logic signed [31:0] tex_v1;
    logic [15:0]        line_count;

    modport source (
        output valid, output pos_x0, output pos_x1, output pos_y0, output pos_y1,
        output tex_u0, output tex_u1, output tex_v0, output tex_v1,
        output line_count, input ready
    );
    modport sink (
        input valid, input pos_x0, input pos_x1, input pos_y0, input pos_y1,
        input tex_u0, input tex_u1, input tex_v0, input tex_v1,
        input line_count, output ready
    );
endinterface

### rtl/gql_cfg_regs.sv
// ----------------------------------------------------------------------------
// gql_cfg_regs
// Configuration register file of the layout block, written by index.
// ----------------------------------------------------------------------------
module gql_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gql_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    output gql_pkg::t_cfg                  o_cfg
);

    gql_pkg::t_cfg r_cfg;
    gql_pkg::t_cfg n_cfg;

    // Decode the write; an index past the list leaves everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                gql_pkg::CFG_TEX_LEFT:      n_cfg.tex_left      = i_cfg_data;
                gql_pkg::CFG_GLYPH_U_WIDTH: n_cfg.glyph_u_width = i_cfg_data;
                gql_pkg::CFG_V_BASE:        n_cfg.v_base        = i_cfg_data;
                gql_pkg::CFG_QUAD_WIDTH:    n_cfg.quad_width    = i_cfg_data;
                gql_pkg::CFG_QUAD_HEIGHT:   n_cfg.quad_height   = i_cfg_data;
                gql_pkg::CFG_ADVANCE:       n_cfg.advance       = i_cfg_data;
                gql_pkg::CFG_WRAP_CHARS:    n_cfg.wrap_chars    = i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_left      <= gql_pkg::RST_TEX_LEFT;
            r_cfg.glyph_u_width <= gql_pkg::RST_GLYPH_U_WIDTH;
            r_cfg.v_base        <= gql_pkg::RST_V_BASE;
            r_cfg.quad_width    <= gql_pkg::RST_QUAD_WIDTH;
            r_cfg.quad_height   <= gql_pkg::RST_QUAD_HEIGHT;
            r_cfg.advance       <= gql_pkg::RST_ADVANCE;
            r_cfg.wrap_chars    <= gql_pkg::RST_WRAP_CHARS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/gql_atlas_tex.sv
// ----------------------------------------------------------------------------
// gql_atlas_tex
// Texture corners of a character's cell in the font atlas.
// ----------------------------------------------------------------------------
module gql_atlas_tex (
    input  logic [7:0]     i_code,
    input  gql_pkg::t_cfg  i_cfg,
    output gql_pkg::t_tex  o_tex
);

    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] u0;
    logic [31:0] v0;

    // Split the code into atlas column and row; the column count is a power of two
    assign col = 8'(i_code % gql_pkg::ATLAS_COLUMNS);
    assign row = 8'(i_code / gql_pkg::ATLAS_COLUMNS);

    // Scale to Q16.16 cell edges and apply the offsets
    assign u0 = 32'(col) * 32'(gql_pkg::CELL_U) + i_cfg.tex_left;
    assign v0 = i_cfg.v_base - 32'(row) * 32'(gql_pkg::CELL_V);

    assign o_tex.u0 = u0;
    assign o_tex.u1 = u0 + i_cfg.glyph_u_width;
    assign o_tex.v0 = v0;
    assign o_tex.v1 = v0 - 32'(gql_pkg::CELL_V);

endmodule

### rtl/gql_cursor.sv
// ----------------------------------------------------------------------------
// gql_cursor
// Running text cursor: position, characters on the line and line breaks.
// ----------------------------------------------------------------------------
module gql_cursor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_code,
    input  logic              i_start,
    input  gql_pkg::t_cfg     i_cfg,
    output gql_pkg::t_cursor  o_cur
);

    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [8:0]  r_chars;
    logic [15:0] r_breaks;
    logic [31:0] n_x;
    logic [31:0] n_y;
    logic [8:0]  n_chars;
    logic [15:0] n_breaks;

    logic [31:0] base_x;
    logic [31:0] base_y;
    logic [8:0]  base_chars;
    logic [15:0] base_breaks;
    logic        wrap_on;
    logic [8:0]  chars_step;
    logic        brk;

    // Start of a new text clears the cursor before this character
    assign base_x      = i_start ? 32'd0 : r_x;
    assign base_y      = i_start ? 32'd0 : r_y;
    assign base_chars  = i_start ? 9'd0  : r_chars;
    assign base_breaks = i_start ? 16'd0 : r_breaks;

    // Count the character only while wrapping is enabled
    assign wrap_on    = i_cfg.wrap_chars != 8'd0;
    assign chars_step = wrap_on ? base_chars + 9'd1 : base_chars;
    assign brk        = (i_code == gql_pkg::NEWLINE_CODE)
                     || (wrap_on && (chars_step > {1'b0, i_cfg.wrap_chars}));

    // Break to a new line or step right
    always_comb begin
        if (brk) begin
            n_x      = 32'd0;
            n_y      = base_y + i_cfg.quad_height;
            n_chars  = 9'd0;
            n_breaks = (base_breaks == gql_pkg::LINE_COUNT_MAX)
                     ? base_breaks : base_breaks + 16'd1;
        end else begin
            n_x      = base_x + i_cfg.advance;
            n_y      = base_y;
            n_chars  = chars_step;
            n_breaks = base_breaks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= 32'd0;
            r_y      <= 32'd0;
            r_chars  <= 9'd0;
            r_breaks <= 16'd0;
        end else if (i_step) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_chars  <= n_chars;
            r_breaks <= n_breaks;
        end
    end

    assign o_cur.x          = base_x;
    assign o_cur.y          = base_y;
    assign o_cur.line_count = n_breaks;

endmodule

### rtl/glyph_quad_layout.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Bitmap font text layout: one glyph quad per character request.
//
//   channel   direction  handshake      payload
//   i_in      in         valid/ready    char_code, start_text
//   o_out     out        valid/ready    pos_x0..tex_v1, line_count
//   cfg       in         i_cfg_we       i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the quad side does not stall; a taken
// request passes the input register, then the result register, where its
// quad is valid. The cursor update is one add and compare.
// Synchronous active-low reset clears cursor, valids and config registers to defaults.
// A stalled result holds; the input register still takes one more request.
// ----------------------------------------------------------------------------
module glyph_quad_layout (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gql_in_if.sink                         i_in,
    gql_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [gql_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);

    gql_pkg::t_cfg    cfg;
    gql_pkg::t_cursor cur;
    gql_pkg::t_tex    tex;

    logic          r_in_valid;
    logic [7:0]    r_code;
    logic          r_start;
    logic          r_out_valid;
    gql_pkg::t_quad r_quad;
    gql_pkg::t_quad n_quad;
    logic          stage_adv;
    logic          in_take;

    gql_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move the held request into the result register when it is free
    assign stage_adv  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || stage_adv;
    assign in_take    = i_in.valid && i_in.ready;

    gql_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (stage_adv),
        .i_code  (r_code),
        .i_start (r_start),
        .i_cfg   (cfg),
        .o_cur   (cur)
    );

    gql_atlas_tex u_tex (
        .i_code (r_code),
        .i_cfg  (cfg),
        .o_tex  (tex)
    );

    // Assemble the quad
    always_comb begin
        n_quad.pos_x0     = cur.x;
        n_quad.pos_x1     = cur.x + cfg.quad_width;
        n_quad.pos_y0     = cur.y;
        n_quad.pos_y1     = cur.y + cfg.quad_height;
        n_quad.tex_u0     = tex.u0;
        n_quad.tex_u1     = tex.u1;
        n_quad.tex_v0     = tex.v0;
        n_quad.tex_v1     = tex.v1;
        n_quad.line_count = cur.line_count;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code  <= i_in.char_code;
            r_start <= i_in.start_text;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv) begin
            r_quad <= n_quad;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pos_x0     = r_quad.pos_x0;
    assign o_out.pos_x1     = r_quad.pos_x1;
    assign o_out.pos_y0     = r_quad.pos_y0;
    assign o_out.pos_y1     = r_quad.pos_y1;
    assign o_out.tex_u0     = r_quad.tex_u0;
    assign o_out.tex_u1     = r_quad.tex_u1;
    assign o_out.tex_v0     = r_quad.tex_v0;
    assign o_out.tex_v1     = r_quad.tex_v1;
    assign o_out.line_count = r_quad.line_count;

endmodule

### rtl/gql_checker.sv
// ----------------------------------------------------------------------------
// gql_checker
// Port-level checks of the glyph quad layout block, bound to the top level.
// ----------------------------------------------------------------------------
module gql_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pos_x0,
    input logic [31:0] i_out_tex_u0,
    input logic [15:0] i_out_line_count
);

    // Hold a stalled quad
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("quad dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pos_x0)
            && $stable(i_out_tex_u0) && $stable(i_out_line_count))
        else $error("stalled quad changed");

    // A quad appears only after a request was taken, via input and result registers
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("quad without request");

    // Input backs up only behind a stalled full result register
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

endmodule

bind glyph_quad_layout gql_checker u_gql_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_pos_x0     (o_out.pos_x0),
    .i_out_tex_u0     (o_out.tex_u0),
    .i_out_line_count (o_out.line_count)
);

### sim/glyph_quad_layout_tb.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_tb
// Self-checking bench for the glyph quad layout block. A predictor keeps its
// own cursor, line state and register copy, works out the quad for every
// accepted character request, and compares each quad that leaves the block
// field by field. Stimulus: directed corner cases, a full-width wrap line,
// then random texts under several random settings, with random gaps on the
// request side and random stalls on the quad side.
// ----------------------------------------------------------------------------
module glyph_quad_layout_tb;

    localparam int QUAD_LATENCY = 2;
    localparam int IDLE_PCT     = 12;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_RUNS  = 4;
    localparam int RUN_CHARS    = 100;
    localparam logic [gql_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // Predictor of the layout: register copy, cursor state, pending quads
    class t_quad_predictor;
        gql_pkg::t_cfg  regs;
        logic [31:0]    cur_x;
        logic [31:0]    cur_y;
        logic [8:0]     line_chars;
        logic [15:0]    breaks;
        gql_pkg::t_quad expected_quads[$];
        int             mismatches;

        function new();
            regs.tex_left      = gql_pkg::RST_TEX_LEFT;
            regs.glyph_u_width = gql_pkg::RST_GLYPH_U_WIDTH;
            regs.v_base        = gql_pkg::RST_V_BASE;
            regs.quad_width    = gql_pkg::RST_QUAD_WIDTH;
            regs.quad_height   = gql_pkg::RST_QUAD_HEIGHT;
            regs.advance       = gql_pkg::RST_ADVANCE;
            regs.wrap_chars    = gql_pkg::RST_WRAP_CHARS;
            cur_x      = '0;
            cur_y      = '0;
            line_chars = '0;
            breaks     = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [gql_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                gql_pkg::CFG_TEX_LEFT:      regs.tex_left      = data;
                gql_pkg::CFG_GLYPH_U_WIDTH: regs.glyph_u_width = data;
                gql_pkg::CFG_V_BASE:        regs.v_base        = data;
                gql_pkg::CFG_QUAD_WIDTH:    regs.quad_width    = data;
                gql_pkg::CFG_QUAD_HEIGHT:   regs.quad_height   = data;
                gql_pkg::CFG_ADVANCE:       regs.advance       = data;
                gql_pkg::CFG_WRAP_CHARS:    regs.wrap_chars    = data[7:0];
                default: ;
            endcase
        endfunction

        // Build the quad for one accepted character and advance the cursor
        function void take_char(logic [7:0] code, logic start);
            gql_pkg::t_quad q;
            logic [31:0]    col;
            logic [31:0]    row;
            logic [31:0]    u0;
            logic [31:0]    v0;
            logic           brk;
            if (start) begin
                cur_x      = '0;
                cur_y      = '0;
                line_chars = '0;
                breaks     = '0;
            end
            col = 32'(code) % gql_pkg::ATLAS_COLUMNS;
            row = 32'(code) / gql_pkg::ATLAS_COLUMNS;
            u0  = 32'(col * gql_pkg::CELL_U) + regs.tex_left;
            v0  = regs.v_base - 32'(row * gql_pkg::CELL_V);

            q.pos_x0 = cur_x;
            q.pos_x1 = cur_x + regs.quad_width;
            q.pos_y0 = cur_y;
            q.pos_y1 = cur_y + regs.quad_height;
            q.tex_u0 = u0;
            q.tex_u1 = u0 + regs.glyph_u_width;
            q.tex_v0 = v0;
            q.tex_v1 = v0 - 32'(gql_pkg::CELL_V);

            // Count the character only while wrapping is on
            if (regs.wrap_chars != 8'd0)
                line_chars = line_chars + 9'd1;
            brk = (code == gql_pkg::NEWLINE_CODE) ||
                  (regs.wrap_chars != 8'd0 && line_chars > {1'b0, regs.wrap_chars});
            if (brk) begin
                cur_y      = cur_y + regs.quad_height;
                cur_x      = '0;
                line_chars = '0;
                if (breaks != gql_pkg::LINE_COUNT_MAX)
                    breaks = breaks + 16'd1;
            end else begin
                cur_x = cur_x + regs.advance;
            end
            q.line_count = breaks;
            expected_quads.push_back(q);
        endfunction

        // Compare one delivered quad with the oldest pending one
        function void check_quad(gql_pkg::t_quad got);
            gql_pkg::t_quad want;
            logic [31:0]    want_f[9];
            logic [31:0]    got_f[9];
            string          names[9] = '{"pos_x0", "pos_x1", "pos_y0", "pos_y1",
                                         "tex_u0", "tex_u1", "tex_v0", "tex_v1",
                                         "line_count"};
            if (expected_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected quad: x0=%h y0=%h u0=%h v0=%h lines=%0d",
                             got.pos_x0, got.pos_y0, got.tex_u0, got.tex_v0,
                             got.line_count);
                return;
            end
            want = expected_quads.pop_front();
            want_f = '{want.pos_x0, want.pos_x1, want.pos_y0, want.pos_y1,
                       want.tex_u0, want.tex_u1, want.tex_v0, want.tex_v1,
                       32'(want.line_count)};
            got_f  = '{got.pos_x0, got.pos_x1, got.pos_y0, got.pos_y1,
                       got.tex_u0, got.tex_u1, got.tex_v0, got.tex_v1,
                       32'(got.line_count)};
            for (int k = 0; k < 9; k++) begin
                if (want_f[k] !== got_f[k]) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("quad %s mismatch: expected %h, got %h",
                                 names[k], want_f[k], got_f[k]);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [gql_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]                   i_cfg_data;
    bit                            steady = 1'b0;
    gql_pkg::t_quad                seen;
    t_quad_predictor               pred;

    gql_in_if  in_if ();
    gql_out_if out_if ();

    glyph_quad_layout dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the quad side at random, except during a steady stretch
    always @(negedge i_clk) begin
        out_if.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check every quad taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.pos_x0     = out_if.pos_x0;
            seen.pos_x1     = out_if.pos_x1;
            seen.pos_y0     = out_if.pos_y0;
            seen.pos_y1     = out_if.pos_y1;
            seen.tex_u0     = out_if.tex_u0;
            seen.tex_u1     = out_if.tex_u1;
            seen.tex_v0     = out_if.tex_v0;
            seen.tex_v1     = out_if.tex_v1;
            seen.line_count = out_if.line_count;
            pred.check_quad(seen);
        end
    end

    // Present one character request, hold it until taken; call at a falling edge
    task automatic send_char(logic [7:0] code, logic start);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_if.valid      <= 1'b1;
        in_if.char_code  <= code;
        in_if.start_text <= start;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        pred.take_char(code, start);
        @(negedge i_clk);
    endtask

    // Drop the request, then wait for every pending quad and let the pipe settle
    task automatic wait_quads_done();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pred.expected_quads.size() != 0)
            @(negedge i_clk);
        repeat (QUAD_LATENCY + 2) @(negedge i_clk);
    endtask

    // Write all registers, plus the unused index which must be ignored
    task automatic load_settings(gql_pkg::t_cfg c);
        logic [31:0] data;
        for (int k = 0; k <= int'(CFG_UNUSED_IDX); k++) begin
            case (3'(k))
                gql_pkg::CFG_TEX_LEFT:      data = c.tex_left;
                gql_pkg::CFG_GLYPH_U_WIDTH: data = c.glyph_u_width;
                gql_pkg::CFG_V_BASE:        data = c.v_base;
                gql_pkg::CFG_QUAD_WIDTH:    data = c.quad_width;
                gql_pkg::CFG_QUAD_HEIGHT:   data = c.quad_height;
                gql_pkg::CFG_ADVANCE:       data = c.advance;
                gql_pkg::CFG_WRAP_CHARS:
                    data = {24'($urandom_range(0, 32'h00FF_FFFF)), c.wrap_chars};
                default:                    data = $urandom();
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= data;
            @(negedge i_clk);
            pred.set_reg(3'(k), data);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom_range(0, 32'h0002_0000);
            6:       return ~$urandom_range(0, 32'h0002_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic gql_pkg::t_cfg random_settings();
        gql_pkg::t_cfg c;
        c.tex_left      = pick_word();
        c.glyph_u_width = pick_word();
        c.v_base        = pick_word();
        c.quad_width    = pick_word();
        c.quad_height   = pick_word();
        c.advance       = pick_word();
        case ($urandom_range(0, 5))
            0:       c.wrap_chars = 8'd0;
            1:       c.wrap_chars = 8'd1;
            2:       c.wrap_chars = 8'd255;
            3:       c.wrap_chars = 8'($urandom_range(0, 255));
            default: c.wrap_chars = 8'($urandom_range(1, 24));
        endcase
        return c;
    endfunction

    // Any code except newline
    function automatic logic [7:0] plain_code();
        logic [7:0] code;
        code = 8'($urandom_range(0, 254));
        if (code >= gql_pkg::NEWLINE_CODE)
            code = code + 8'd1;
        return code;
    endfunction

    // Run limit
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        gql_pkg::t_cfg c;
        logic          start;
        pred = new();
        in_if.valid      = 1'b0;
        in_if.char_code  = '0;
        in_if.start_text = 1'b0;
        out_if.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: atlas corners, newline, start of text
        send_char(8'd0, 1'b1);
        send_char(8'd255, 1'b0);
        send_char(gql_pkg::NEWLINE_CODE, 1'b0);
        send_char(8'd65, 1'b0);
        send_char(8'd15, 1'b0);
        send_char(8'd16, 1'b0);
        send_char(8'd240, 1'b0);
        send_char(gql_pkg::NEWLINE_CODE, 1'b1);
        send_char(8'd9, 1'b0);
        send_char(8'd11, 1'b0);
        wait_quads_done();

        // Positive extremes that make the adds overflow, wrap on the third character
        c.tex_left      = 32'h7FFF_FFFF;
        c.glyph_u_width = 32'h7FFF_FFFF;
        c.v_base        = 32'h8000_0000;
        c.quad_width    = 32'h7FFF_FFFF;
        c.quad_height   = 32'h7FFF_FFFF;
        c.advance       = 32'h7FFF_FFFF;
        c.wrap_chars    = 8'd2;
        load_settings(c);
        send_char(8'h41, 1'b1);
        send_char(8'h42, 1'b0);
        send_char(8'h43, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(gql_pkg::NEWLINE_CODE, 1'b0);
        send_char(8'h00, 1'b0);
        wait_quads_done();

        // Negative extremes, wrap off mid-text: line count holds
        c.tex_left      = 32'h8000_0000;
        c.glyph_u_width = 32'h8000_0000;
        c.v_base        = 32'h7FFF_FFFF;
        c.quad_width    = 32'h8000_0000;
        c.quad_height   = 32'h8000_0000;
        c.advance       = 32'hFFFF_FFFF;
        c.wrap_chars    = 8'd0;
        load_settings(c);
        repeat (4) send_char(plain_code(), 1'b0);
        wait_quads_done();

        // Wrap count set to one mid-text
        c.wrap_chars = 8'd1;
        load_settings(c);
        repeat (4) send_char(plain_code(), 1'b0);
        wait_quads_done();

        // Widest wrap: a full line of 256 characters before the break
        c = random_settings();
        c.wrap_chars = 8'd255;
        load_settings(c);
        send_char(plain_code(), 1'b1);
        repeat (259) send_char(plain_code(), 1'b0);
        wait_quads_done();

        // Random texts under random settings
        for (int run = 0; run < RANDOM_RUNS; run++) begin
            load_settings(random_settings());
            steady = (run == 3);
            for (int n = 0; n < RUN_CHARS; n++) begin
                if (run == 1 && n == RUN_CHARS / 2)
                    wait_quads_done();
                start = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_char(gql_pkg::NEWLINE_CODE, start);
                else
                    send_char(8'($urandom_range(0, 255)), start);
            end
            wait_quads_done();
            steady = 1'b0;
        end

        if (pred.mismatches == 0 && pred.expected_quads.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/gql_pkg.sv
rtl/gql_ifs.sv
rtl/gql_cfg_regs.sv
rtl/gql_atlas_tex.sv
rtl/gql_cursor.sv
rtl/glyph_quad_layout.sv
rtl/gql_checker.sv
sim/glyph_quad_layout_tb.sv
